### rtl/core/svb_pkg.sv
package svb_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int SIDE_BITS  = 12;
  // Signed working width for doubled coordinates and their differences
  localparam int GEO_BITS   = COORD_BITS + 4;
  // Squared distance width
  localparam int SQ_BITS    = 2 * (GEO_BITS - 1);
  // Root / numerator width
  localparam int N_BITS     = 2 * SIDE_BITS;
  // Iterative units: stages and steps per stage
  localparam int STAGES     = 4;
  localparam int STEPS_PER  = SIDE_BITS / STAGES;

  typedef logic signed [GEO_BITS-1:0] geo_t;
  typedef logic [SIDE_BITS-1:0]       side_t;
  typedef logic [N_BITS-1:0]          wn_t;

  // Per-transaction pipeline record
  typedef struct packed {
    logic  vld;
    logic  mode;
    logic  hit;
    logic  aln;     // circle centre aligned with clamp point on an axis
    geo_t  px;      // offsets for square mode or aligned circle case
    geo_t  py;
    logic  sx;      // sign of centre minus clamp point
    logic  sy;
    side_t adx;     // magnitude of centre minus clamp point
    side_t ady;
    side_t r;
    wn_t   n;       // root remainder
    wn_t   root;
    side_t d;       // distance
    wn_t   remx;    // divider remainders
    wn_t   remy;
    side_t qx;
    side_t qy;
  } pl_t;

  typedef struct packed {
    wn_t n;
    wn_t root;
  } isq_t;

  typedef struct packed {
    wn_t   rem;
    side_t q;
  } dv_t;

  function automatic geo_t ext_coord(logic [COORD_BITS-1:0] v);
    return geo_t'({{(GEO_BITS-COORD_BITS){1'b0}}, v});
  endfunction

  function automatic geo_t ext_side(side_t v);
    return geo_t'({{(GEO_BITS-SIDE_BITS){1'b0}}, v});
  endfunction

  // Offset toward the nearer edge
  function automatic geo_t nearer(geo_t to_neg, geo_t to_pos);
    return (to_neg < to_pos) ? -to_neg : to_pos;
  endfunction

  // One bit of the square root, bit weight 4^k
  function automatic isq_t isq_step(isq_t s, int k);
    isq_t o;
    wn_t  bb;
    wn_t  t;
    bb = wn_t'(1) << (2 * k);
    t  = s.root + bb;
    if (s.n >= t) begin
      o.n    = s.n - t;
      o.root = (s.root >> 1) + bb;
    end else begin
      o.n    = s.n;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division, weight 2^k
  function automatic dv_t div_step(dv_t s, side_t d, int k);
    dv_t o;
    wn_t ds;
    ds = wn_t'(d) << k;
    o  = s;
    if (s.rem >= ds) begin
      o.rem = s.rem - ds;
      o.q   = s.q | (side_t'(1) << k);
    end
    return o;
  endfunction

  // Divide by 2^sh, truncating toward zero
  function automatic geo_t tdiv(geo_t v, logic [1:0] sh);
    geo_t m;
    m = (v < 0) ? -v : v;
    m = m >> sh;
    return (v < 0) ? -m : m;
  endfunction

endpackage

### rtl/core/square_vs_box_overlap_offset.sv
// Square or circle mover against an axis-aligned box, one test per clock.
// A transaction is taken whenever start is high; busy is never asserted.
// Each result appears on the out_ ports for one cycle, flagged by out_strobe,
// in issue order. It passes through the 4-stage geometry front end, the
// 4-stage square root (3 bits per stage), the multiply stage plus 4-stage
// divider (3 quotient bits per stage), and the output register.
// The receiver cannot stall; results must be captured on
// the strobe cycle.
module square_vs_box_overlap_offset import svb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [COORD_BITS-1:0]      in_mover_x,
  input  logic [COORD_BITS-1:0]      in_mover_y,
  input  logic [SIDE_BITS-1:0]       in_mover_side,
  input  logic [COORD_BITS-1:0]      in_box_left,
  input  logic [COORD_BITS-1:0]      in_box_top,
  input  logic [SIDE_BITS-1:0]       in_box_width,
  input  logic [SIDE_BITS-1:0]       in_box_height,
  output logic                       out_strobe,
  output logic                       out_hit,
  output logic signed [COORD_BITS:0] out_push_x,
  output logic signed [COORD_BITS:0] out_push_y
);

  pl_t fr, sq, dv;

  assign busy = 1'b0;

  svb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .mode     (in_mode),
    .mover_x  (in_mover_x),
    .mover_y  (in_mover_y),
    .side     (in_mover_side),
    .box_left (in_box_left),
    .box_top  (in_box_top),
    .box_w    (in_box_width),
    .box_h    (in_box_height),
    .pl_o     (fr)
  );

  svb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .pl_i  (fr),
    .pl_o  (sq)
  );

  svb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .pl_i  (sq),
    .pl_o  (dv)
  );

  // Pick offsets and keep the smaller axis (both, halved, on a tie; zero on a miss)
  geo_t       ox, oy, ax, ay, rx, ry;
  logic [1:0] sh;

  always_comb begin
    if (!dv.mode || dv.aln) begin
      ox = dv.px;
      oy = dv.py;
    end else begin
      ox = dv.sx ? -ext_side(dv.qx) : ext_side(dv.qx);
      oy = dv.sy ? -ext_side(dv.qy) : ext_side(dv.qy);
    end
    sh = {1'b0, dv.mode};
    ax = (ox < 0) ? -ox : ox;
    ay = (oy < 0) ? -oy : oy;
    priority if (!dv.hit) begin
      rx = '0;
      ry = '0;
    end else if (ax > ay) begin
      rx = '0;
      ry = tdiv(oy, sh);
    end else if (ax < ay) begin
      rx = tdiv(ox, sh);
      ry = '0;
    end else begin
      rx = tdiv(ox, sh + 2'd1);
      ry = tdiv(oy, sh + 2'd1);
    end
  end

  // Output register
  logic                       out_strobe_r, out_hit_r;
  logic signed [COORD_BITS:0] push_x_r, push_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv.vld;
    end
    out_hit_r <= dv.hit;
    push_x_r  <= rx[COORD_BITS:0];
    push_y_r  <= ry[COORD_BITS:0];
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;
  assign out_push_x = push_x_r;
  assign out_push_y = push_y_r;

`ifndef SYNTHESIS
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_hit |-> out_push_x == '0 && out_push_y == '0)
    else $error("nonzero push on miss");
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_push_x != '0 && out_push_y != '0 |->
    (out_push_x == out_push_y) || (out_push_x == -out_push_y))
    else $error("both axes kept without a tie");
`endif

endmodule

### rtl/core/svb_front.sv
module svb_front import svb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] mover_x,
  input  logic [COORD_BITS-1:0] mover_y,
  input  side_t                 side,
  input  logic [COORD_BITS-1:0] box_left,
  input  logic [COORD_BITS-1:0] box_top,
  input  side_t                 box_w,
  input  side_t                 box_h,
  output pl_t                   pl_o
);

  // Stage 1: edges and depths
  logic  s1_vld_r, s1_mode_r;
  side_t s1_r_r;
  geo_t  s1_cx_r, s1_cy_r, s1_lo_r, s1_ro_r, s1_to_r, s1_bo_r;
  geo_t  s1_dl_r, s1_dr_r, s1_dt_r, s1_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_mode_r <= mode;
    s1_r_r    <= side;
    s1_cx_r   <= (ext_coord(mover_x) <<< 1) + ext_side(side);
    s1_cy_r   <= (ext_coord(mover_y) <<< 1) + ext_side(side);
    s1_lo_r   <= ext_coord(box_left) <<< 1;
    s1_ro_r   <= (ext_coord(box_left) + ext_side(box_w)) <<< 1;
    s1_to_r   <= ext_coord(box_top) <<< 1;
    s1_bo_r   <= (ext_coord(box_top) + ext_side(box_h)) <<< 1;
    s1_dl_r   <= ext_coord(mover_x) + ext_side(side) - ext_coord(box_left);
    s1_dr_r   <= ext_coord(box_left) + ext_side(box_w) - ext_coord(mover_x);
    s1_dt_r   <= ext_coord(mover_y) + ext_side(side) - ext_coord(box_top);
    s1_db_r   <= ext_coord(box_top) + ext_side(box_h) - ext_coord(mover_y);
  end

  // Stage 2: square-mode offsets, clamp, aligned-case offsets
  logic  s2_vld_r, s2_mode_r, s2_hit0_r;
  side_t s2_r_r;
  geo_t  s2_p0x_r, s2_p0y_r, s2_pax_r, s2_pay_r, s2_dx_r, s2_dy_r;
  geo_t  qx, qy, rg;

  always_comb begin
    rg = ext_side(s1_r_r);
    priority if (s1_cx_r < s1_lo_r) qx = s1_lo_r;
    else if (s1_cx_r > s1_ro_r)     qx = s1_ro_r;
    else                            qx = s1_cx_r;
    priority if (s1_cy_r < s1_to_r) qy = s1_to_r;
    else if (s1_cy_r > s1_bo_r)     qy = s1_bo_r;
    else                            qy = s1_cy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_mode_r <= s1_mode_r;
    s2_r_r    <= s1_r_r;
    s2_hit0_r <= (s1_dl_r > 0) && (s1_dr_r > 0) && (s1_dt_r > 0) && (s1_db_r > 0);
    s2_p0x_r  <= nearer(s1_dl_r, s1_dr_r);
    s2_p0y_r  <= nearer(s1_dt_r, s1_db_r);
    s2_pax_r  <= nearer(s1_cx_r - s1_lo_r + rg, s1_ro_r - s1_cx_r + rg);
    s2_pay_r  <= nearer(s1_cy_r - s1_to_r + rg, s1_bo_r - s1_cy_r + rg);
    s2_dx_r   <= s1_cx_r - qx;
    s2_dy_r   <= s1_cy_r - qy;
  end

  // Stage 3: squares
  logic                s3_vld_r, s3_mode_r, s3_hit0_r;
  side_t               s3_r_r;
  geo_t                s3_p0x_r, s3_p0y_r, s3_pax_r, s3_pay_r;
  logic                s3_sx_r, s3_sy_r;
  logic [GEO_BITS-2:0] adx, ady;
  logic [SQ_BITS-1:0]  s3_sqx_r, s3_sqy_r;
  logic [N_BITS-1:0]   s3_rr_r;
  side_t               s3_adx_r, s3_ady_r;

  always_comb begin
    adx = s2_dx_r[GEO_BITS-1] ? (GEO_BITS-1)'(-s2_dx_r) : s2_dx_r[GEO_BITS-2:0];
    ady = s2_dy_r[GEO_BITS-1] ? (GEO_BITS-1)'(-s2_dy_r) : s2_dy_r[GEO_BITS-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_mode_r <= s2_mode_r;
    s3_hit0_r <= s2_hit0_r;
    s3_r_r    <= s2_r_r;
    s3_p0x_r  <= s2_p0x_r;
    s3_p0y_r  <= s2_p0y_r;
    s3_pax_r  <= s2_pax_r;
    s3_pay_r  <= s2_pay_r;
    s3_sx_r   <= s2_dx_r[GEO_BITS-1];
    s3_sy_r   <= s2_dy_r[GEO_BITS-1];
    s3_adx_r  <= adx[SIDE_BITS-1:0];
    s3_ady_r  <= ady[SIDE_BITS-1:0];
    s3_sqx_r  <= adx * adx;
    s3_sqy_r  <= ady * ady;
    s3_rr_r   <= s2_r_r * s2_r_r;
  end

  // Stage 4: distance test and record build
  logic [SQ_BITS:0] dsq;
  logic             hit1;
  pl_t              pl_nxt, pl_r;

  always_comb begin
    dsq  = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
    hit1 = dsq < {{(SQ_BITS+1-N_BITS){1'b0}}, s3_rr_r};
    pl_nxt      = '0;
    pl_nxt.vld  = s3_vld_r;
    pl_nxt.mode = s3_mode_r;
    pl_nxt.hit  = s3_mode_r ? hit1 : s3_hit0_r;
    pl_nxt.aln  = (s3_adx_r == '0 && s3_sqx_r == '0) || (s3_ady_r == '0 && s3_sqy_r == '0);
    pl_nxt.px   = s3_mode_r ? s3_pax_r : s3_p0x_r;
    pl_nxt.py   = s3_mode_r ? s3_pay_r : s3_p0y_r;
    pl_nxt.sx   = s3_sx_r;
    pl_nxt.sy   = s3_sy_r;
    pl_nxt.adx  = s3_adx_r;
    pl_nxt.ady  = s3_ady_r;
    pl_nxt.r    = s3_r_r;
    pl_nxt.n    = dsq[N_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= '0;
    end else begin
      pl_r <= pl_nxt;
    end
  end

  assign pl_o = pl_r;

endmodule

### rtl/core/svb_isqrt.sv
module svb_isqrt import svb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  pl_t  pl_i,
  output pl_t  pl_o
);

  pl_t stg_in  [STAGES];
  pl_t stg_nxt [STAGES];
  pl_t stg_r   [STAGES];

  // Integer square root, STEPS_PER result bits per stage, MSB first
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign stg_in[g] = pl_i;
    end else begin : g_next
      assign stg_in[g] = stg_r[g-1];
    end

    always_comb begin
      isq_t s;
      s.n    = stg_in[g].n;
      s.root = stg_in[g].root;
      for (int j = 0; j < STEPS_PER; j++) begin
        s = isq_step(s, SIDE_BITS - 1 - g * STEPS_PER - j);
      end
      stg_nxt[g]      = stg_in[g];
      stg_nxt[g].n    = s.n;
      stg_nxt[g].root = s.root;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[g] <= '0;
      end else begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

  assign pl_o = stg_r[STAGES-1];

endmodule

### rtl/core/svb_div.sv
module svb_div import svb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  pl_t  pl_i,
  output pl_t  pl_o
);

  // Numerators: |delta| * (radius - distance)
  pl_t   pr_nxt, pr_r;
  side_t dd, rd;

  always_comb begin
    dd          = (pl_i.root[SIDE_BITS-1:0] == '0) ? side_t'(1) : pl_i.root[SIDE_BITS-1:0];
    rd          = pl_i.r - dd;
    pr_nxt      = pl_i;
    pr_nxt.d    = dd;
    pr_nxt.remx = pl_i.adx * rd;
    pr_nxt.remy = pl_i.ady * rd;
    pr_nxt.qx   = '0;
    pr_nxt.qy   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_r <= '0;
    end else begin
      pr_r <= pr_nxt;
    end
  end

  // Restoring division of both axes, STEPS_PER quotient bits per stage
  pl_t stg_in  [STAGES];
  pl_t stg_nxt [STAGES];
  pl_t stg_r   [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign stg_in[g] = pr_r;
    end else begin : g_next
      assign stg_in[g] = stg_r[g-1];
    end

    always_comb begin
      dv_t sx;
      dv_t sy;
      sx.rem = stg_in[g].remx;
      sx.q   = stg_in[g].qx;
      sy.rem = stg_in[g].remy;
      sy.q   = stg_in[g].qy;
      for (int j = 0; j < STEPS_PER; j++) begin
        sx = div_step(sx, stg_in[g].d, SIDE_BITS - 1 - g * STEPS_PER - j);
        sy = div_step(sy, stg_in[g].d, SIDE_BITS - 1 - g * STEPS_PER - j);
      end
      stg_nxt[g]      = stg_in[g];
      stg_nxt[g].remx = sx.rem;
      stg_nxt[g].qx   = sx.q;
      stg_nxt[g].remy = sy.rem;
      stg_nxt[g].qy   = sy.q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[g] <= '0;
      end else begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

  assign pl_o = stg_r[STAGES-1];

endmodule
